// ===== rtl/fbc_pkg.sv =====
package fbc_pkg;

  // Cipher geometry
  localparam int unsigned BlockW  = 32;
  localparam int unsigned HalfW   = 16;
  localparam int unsigned Rounds  = 4;
  localparam int unsigned RotAmt  = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [BlockW-1:0] IvReset = 32'h1234_5678;

  typedef logic [HalfW-1:0] half_t;
  typedef half_t [Rounds-1:0] key_set_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY0    = 3'd0,
    REG_KEY1    = 3'd1,
    REG_KEY2    = 3'd2,
    REG_KEY3    = 3'd3,
    REG_MODE    = 3'd4,
    REG_DECRYPT = 3'd5,
    REG_IV      = 3'd6
  } cfg_reg_e;

  // Round function: rotate left by RotAmt, then mix in the round key
  function automatic half_t round_fn(input half_t x, input half_t k);
    return {x[HalfW-1-RotAmt:0], x[HalfW-1:HalfW-RotAmt]} ^ k;
  endfunction

endpackage

// ===== rtl/feistel_block_cipher_ecb_cbc_core.sv =====
// Channel  Handshake                      Payload
// in       in_valid_i / in_ready_o        data_block_i, first_block_i
// out      out_valid_o / out_ready_i      result_block_o
// cfg      cfg_we_i (no wait)             cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled; an accepted word
// goes into the input register, then through four rounds of rotate/xor into the
// result register, from which it leaves. The CBC chain register closes its loop within
// stage one. Reset clears keys and modes and loads the initial vector into both
// the IV and chain registers. A stalled output holds the result register; the
// input takes one more word, then drops ready.
module feistel_block_cipher_ecb_cbc_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [fbc_pkg::BlockW-1:0]          data_block_i,
  input  logic                                first_block_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fbc_pkg::BlockW-1:0]          result_block_o,
  input  logic                                cfg_we_i,
  input  logic [fbc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [fbc_pkg::BlockW-1:0]          cfg_data_i
);

  fbc_pkg::key_set_t                key_q;
  logic                             mode_q;
  logic                             decrypt_q;
  logic [fbc_pkg::BlockW-1:0]       iv_q;
  logic [fbc_pkg::BlockW-1:0]       chain_q, chain_d;

  logic                             s1_valid_q;
  logic [fbc_pkg::BlockW-1:0]       s1_data_q;
  logic                             s1_first_q;

  logic                             out_valid_q;
  logic [fbc_pkg::BlockW-1:0]       out_data_q;

  logic                             s1_adv;
  logic                             in_fire;
  logic [fbc_pkg::BlockW-1:0]       chain_cur;
  logic [fbc_pkg::BlockW-1:0]       cipher_in;
  logic [fbc_pkg::BlockW-1:0]       cipher_out;
  logic [fbc_pkg::BlockW-1:0]       result;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      mode_q    <= 1'b0;
      decrypt_q <= 1'b0;
      iv_q      <= fbc_pkg::IvReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        fbc_pkg::REG_KEY0, fbc_pkg::REG_KEY1, fbc_pkg::REG_KEY2, fbc_pkg::REG_KEY3: begin
          key_q[cfg_index_i[1:0]] <= cfg_data_i[fbc_pkg::HalfW-1:0];
        end
        fbc_pkg::REG_MODE:    mode_q    <= cfg_data_i[0];
        fbc_pkg::REG_DECRYPT: decrypt_q <= cfg_data_i[0];
        fbc_pkg::REG_IV:      iv_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow: stage one advances when the output slot is free or draining
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q  <= data_block_i;
      s1_first_q <= first_block_i;
    end
  end

  // Chaining value seen by this word: IV at a message start
  assign chain_cur = s1_first_q ? iv_q : chain_q;

  // Whiten the input before encryption in CBC
  assign cipher_in = (mode_q && !decrypt_q) ? (s1_data_q ^ chain_cur) : s1_data_q;

  fbc_rounds u_rounds (
    .keys_i    (key_q),
    .decrypt_i (decrypt_q),
    .block_i   (cipher_in),
    .block_o   (cipher_out)
  );

  // Unwhiten after decryption in CBC
  assign result = (mode_q && decrypt_q) ? (cipher_out ^ chain_cur) : cipher_out;

  // Next chaining value: ciphertext of this word in CBC, else the current chaining value
  always_comb begin
    chain_d = chain_cur;
    if (mode_q) begin
      chain_d = decrypt_q ? s1_data_q : result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= fbc_pkg::IvReset;
    end else if (s1_valid_q && s1_adv) begin
      chain_q <= chain_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_block_o = out_data_q;

`ifndef SYNTH
  // A word leaving stage one lands in the result register
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_adv |=> out_valid_q)
    else $error("stage one word lost");

  // Input only stalls when both stages are full and the output is blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // ECB leaves the chain alone except for an IV load
  a_ecb_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mode_q && s1_valid_q && s1_adv && !s1_first_q |=> $stable(chain_q))
    else $error("chain changed in ECB mode");

  // A stalled stage one holds the chaining value
  a_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q || !s1_adv |=> $stable(chain_q))
    else $error("chain changed without a word moving");
`endif

endmodule

// ===== rtl/fbc_rounds.sv =====
module fbc_rounds (
  input  fbc_pkg::key_set_t              keys_i,
  input  logic                           decrypt_i,
  input  logic [fbc_pkg::BlockW-1:0]     block_i,
  output logic [fbc_pkg::BlockW-1:0]     block_o
);

  fbc_pkg::half_t left  [fbc_pkg::Rounds+1];
  fbc_pkg::half_t right [fbc_pkg::Rounds+1];
  fbc_pkg::half_t rkey  [fbc_pkg::Rounds];

  // Pick round keys: forward order to encrypt, reversed to decrypt
  always_comb begin
    for (int r = 0; r < fbc_pkg::Rounds; r++) begin
      rkey[r] = decrypt_i ? keys_i[fbc_pkg::Rounds-1-r] : keys_i[r];
    end
  end

  // Run the Feistel rounds; low half enters as left
  always_comb begin
    left[0]  = block_i[fbc_pkg::HalfW-1:0];
    right[0] = block_i[fbc_pkg::BlockW-1:fbc_pkg::HalfW];
    for (int r = 0; r < fbc_pkg::Rounds; r++) begin
      left[r+1]  = right[r];
      right[r+1] = left[r] ^ fbc_pkg::round_fn(right[r], rkey[r]);
    end
  end

  // Swap halves on the way out
  assign block_o = {left[fbc_pkg::Rounds], right[fbc_pkg::Rounds]};

endmodule
